FILE: rtl/pwmm_pkg.sv
// ----------------------------------------------------------------------------
// pwmm_pkg
// Shared constants and types of the PWM duty and frequency meter.
// ----------------------------------------------------------------------------
package pwmm_pkg;

    localparam int CNT_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int TPS_BITS      = 24;
    localparam int TICKS_BITS    = 16;
    localparam int DUTY_BITS     = 7;
    localparam int FREQ_BITS     = 16;
    localparam int DUTY_SCALE    = 100;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 2;

    localparam logic [TPS_BITS-1:0]      TPS_RESET    = 24'd1000000;
    localparam logic [APB_ADDR_BITS-1:0] REG_TPS_ADDR = 2'd0;

    // edge_kind codes
    localparam logic EDGE_RISE = 1'b0;
    localparam logic EDGE_FALL = 1'b1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: rtl/pwmm_fifo.sv
// ----------------------------------------------------------------------------
// pwmm_fifo
// Small capture queue between the edge front end and the divider back end.
// ----------------------------------------------------------------------------
module pwmm_fifo
    import pwmm_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fifo_status_t     stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/pwmm_front.sv
// ----------------------------------------------------------------------------
// pwmm_front
// Tick counter and alternating edge detector; queues one job per capture.
// ----------------------------------------------------------------------------
module pwmm_front
    import pwmm_pkg::*;
#(
    parameter int COUNTER_BITS = CNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    signal_level,
    input  fifo_status_t            q_stat,
    output logic                    push,
    output logic [2*COUNTER_BITS:0] push_data
);

    logic [COUNTER_BITS-1:0] tick_reg;
    logic [COUNTER_BITS-1:0] tick_next;
    logic                    await_reg;
    logic                    await_next;
    logic                    prev_reg;
    logic                    prev_next;
    logic [COUNTER_BITS-1:0] high_reg;
    logic [COUNTER_BITS-1:0] high_next;
    logic [COUNTER_BITS-1:0] low_reg;
    logic [COUNTER_BITS-1:0] low_next;
    logic [COUNTER_BITS-1:0] count;
    logic                    accept;
    logic                    cap_rise;
    logic                    cap_fall;

    // any sample may capture, so hold off whenever the queue is full
    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign count    = tick_reg + COUNTER_BITS'(1);
    assign cap_rise = !await_reg && signal_level && !prev_reg;
    assign cap_fall = await_reg && !signal_level && prev_reg;
    assign push     = accept && (cap_rise || cap_fall);

    always_comb
    begin
        tick_next  = tick_reg;
        await_next = await_reg;
        prev_next  = prev_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        push_data  = {EDGE_RISE, high_reg, count};
        if (accept)
        begin
            prev_next = signal_level;
            if (cap_rise)
            begin
                low_next   = count;
                await_next = 1'b1;
                tick_next  = '0;
            end
            else if (cap_fall)
            begin
                high_next  = count;
                await_next = 1'b0;
                tick_next  = '0;
                push_data  = {EDGE_FALL, count, low_reg};
            end
            else
            begin
                tick_next = count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            await_reg <= 1'b0;
            prev_reg  <= 1'b0;
            high_reg  <= '0;
            low_reg   <= '0;
        end
        else
        begin
            tick_reg  <= tick_next;
            await_reg <= await_next;
            prev_reg  <= prev_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
        end
    end

endmodule

FILE: rtl/pwmm_back.sv
// ----------------------------------------------------------------------------
// pwmm_back
// Computes duty and frequency per queued capture with two restoring
// dividers stepped in lockstep, one quotient bit per cycle each.
// ----------------------------------------------------------------------------
module pwmm_back
    import pwmm_pkg::*;
#(
    parameter int COUNTER_BITS = CNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fifo_status_t            q_stat,
    input  logic [2*COUNTER_BITS:0] pop_data,
    output logic                    pop,
    input  logic [TPS_BITS-1:0]     tps,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    edge_kind,
    output logic [TICKS_BITS-1:0]   high_ticks,
    output logic [TICKS_BITS-1:0]   low_ticks,
    output logic [DUTY_BITS-1:0]    duty_percent,
    output logic [FREQ_BITS-1:0]    frequency,
    output logic                    period_zero
);

    localparam int PW = COUNTER_BITS + 1;
    localparam int MW = COUNTER_BITS + 7;
    localparam int DW = (MW > TPS_BITS) ? MW : TPS_BITS;
    localparam int SW = $clog2(DW);

    bk_state_t state_reg;
    bk_state_t state_next;

    logic                    q_kind;
    logic [COUNTER_BITS-1:0] q_hi;
    logic [COUNTER_BITS-1:0] q_lo;
    logic [PW-1:0]           per_load;
    logic                    do_step;
    logic                    finish;

    logic                    kind_reg;
    logic [COUNTER_BITS-1:0] hi_reg;
    logic [COUNTER_BITS-1:0] lo_reg;
    logic [PW-1:0]           per_reg;
    logic                    pzero_reg;
    logic [SW-1:0]           step_reg;
    logic [PW-1:0]           rem_d_reg;
    logic [PW-1:0]           rem_d_next;
    logic [PW-1:0]           rem_f_reg;
    logic [PW-1:0]           rem_f_next;
    logic [DW-1:0]           num_d_reg;
    logic [DW-1:0]           num_d_next;
    logic [DW-1:0]           num_f_reg;
    logic [DW-1:0]           num_f_next;
    logic [PW:0]             sh_d;
    logic [PW:0]             sh_f;
    logic [PW:0]             diff_d;
    logic [PW:0]             diff_f;
    logic                    ge_d;
    logic                    ge_f;
    logic [FREQ_BITS-1:0]    freq_sat;

    logic                    out_valid_reg;
    logic                    edge_kind_reg;
    logic [TICKS_BITS-1:0]   high_ticks_reg;
    logic [TICKS_BITS-1:0]   low_ticks_reg;
    logic [DUTY_BITS-1:0]    duty_reg;
    logic [FREQ_BITS-1:0]    freq_reg;
    logic                    pzero_out_reg;

    assign q_kind   = pop_data[2*COUNTER_BITS];
    assign q_hi     = pop_data[2*COUNTER_BITS-1:COUNTER_BITS];
    assign q_lo     = pop_data[COUNTER_BITS-1:0];
    assign per_load = PW'(q_hi) + PW'(q_lo);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = (per_load == '0) ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop     = 1'b0;
        do_step = 1'b0;
        finish  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop = !q_stat.empty;
            end
            BK_DIV:
            begin
                do_step = 1'b1;
            end
            BK_DONE:
            begin
                finish = !out_valid_reg || out_ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // one restoring step for each divider
    always_comb
    begin
        sh_d       = {rem_d_reg, num_d_reg[DW-1]};
        sh_f       = {rem_f_reg, num_f_reg[DW-1]};
        diff_d     = sh_d - {1'b0, per_reg};
        diff_f     = sh_f - {1'b0, per_reg};
        ge_d       = (sh_d >= {1'b0, per_reg});
        ge_f       = (sh_f >= {1'b0, per_reg});
        rem_d_next = ge_d ? diff_d[PW-1:0] : sh_d[PW-1:0];
        rem_f_next = ge_f ? diff_f[PW-1:0] : sh_f[PW-1:0];
        num_d_next = {num_d_reg[DW-2:0], ge_d};
        num_f_next = {num_f_reg[DW-2:0], ge_f};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= q_kind;
            hi_reg    <= q_hi;
            lo_reg    <= q_lo;
            per_reg   <= per_load;
            pzero_reg <= (per_load == '0);
            step_reg  <= SW'(DW - 1);
            rem_d_reg <= '0;
            rem_f_reg <= '0;
            if (per_load == '0)
            begin
                num_d_reg <= '0;
                num_f_reg <= '0;
            end
            else
            begin
                num_d_reg <= DW'(q_hi) * DW'(DUTY_SCALE);
                num_f_reg <= DW'(tps);
            end
        end
        else if (do_step)
        begin
            step_reg  <= step_reg - SW'(1);
            rem_d_reg <= rem_d_next;
            rem_f_reg <= rem_f_next;
            num_d_reg <= num_d_next;
            num_f_reg <= num_f_next;
        end
    end

    assign freq_sat = (|num_f_reg[DW-1:FREQ_BITS]) ? '1 : num_f_reg[FREQ_BITS-1:0];

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            edge_kind_reg  <= kind_reg;
            high_ticks_reg <= TICKS_BITS'(hi_reg);
            low_ticks_reg  <= TICKS_BITS'(lo_reg);
            duty_reg       <= num_d_reg[DUTY_BITS-1:0];
            freq_reg       <= freq_sat;
            pzero_out_reg  <= pzero_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign edge_kind    = edge_kind_reg;
    assign high_ticks   = high_ticks_reg;
    assign low_ticks    = low_ticks_reg;
    assign duty_percent = duty_reg;
    assign frequency    = freq_reg;
    assign period_zero  = pzero_out_reg;

endmodule

FILE: rtl/pwm_duty_frequency_meter.sv
// ----------------------------------------------------------------------------
// pwm_duty_frequency_meter
// Input-capture PWM meter: high/low time, duty percent and frequency.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the capture queue has room.
// Each capture is popped in IDLE, divided bit-serially in DIV and registered in DONE;
// the dividers are DW = max(COUNTER_BITS+7, 24) bits wide (24 at the default width).
// A capture waits in the queue while the back end is busy with an earlier one;
// up to QUEUE_DEPTH captures are absorbed before samples stall.
// Reset clears counter, edge state and queue; ticks_per_second reloads 1000000.
module pwm_duty_frequency_meter
    import pwmm_pkg::*;
#(
    parameter int COUNTER_BITS = CNT_BITS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     signal_level,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     edge_kind,
    output logic [TICKS_BITS-1:0]    high_ticks,
    output logic [TICKS_BITS-1:0]    low_ticks,
    output logic [DUTY_BITS-1:0]     duty_percent,
    output logic [FREQ_BITS-1:0]     frequency,
    output logic                     period_zero
);

    localparam int QW = 2 * COUNTER_BITS + 1;

    logic [TPS_BITS-1:0] tps_reg;
    logic                q_push;
    logic [QW-1:0]       q_push_data;
    logic                q_pop;
    logic [QW-1:0]       q_pop_data;
    fifo_status_t        q_stat;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TPS_ADDR) ? APB_DATA_BITS'(tps_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (psel && penable && pwrite && (paddr == REG_TPS_ADDR))
        begin
            tps_reg <= pwdata[TPS_BITS-1:0];
        end
    end

    pwmm_front #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .signal_level (signal_level),
        .q_stat       (q_stat),
        .push         (q_push),
        .push_data    (q_push_data)
    );

    pwmm_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    pwmm_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .pop_data     (q_pop_data),
        .pop          (q_pop),
        .tps          (tps_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .edge_kind    (edge_kind),
        .high_ticks   (high_ticks),
        .low_ticks    (low_ticks),
        .duty_percent (duty_percent),
        .frequency    (frequency),
        .period_zero  (period_zero)
    );

`ifndef NO_ASSERTIONS
    // a capture never lands on a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("capture pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_percent <= DUTY_BITS'(DUTY_SCALE)))
        else $error("duty above 100 percent");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && period_zero) |-> (duty_percent == '0 && frequency == '0))
        else $error("zero period with nonzero duty or frequency");

    // a pop is only issued with data in the queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

FILE: verif/pwm_duty_frequency_meter_tb.sv
// ----------------------------------------------------------------------------
// pwm_duty_frequency_meter_tb
// Feeds PWM sample streams through valid/ready with random gaps on both sides,
// programs the tick rate over APB between phases, and checks every capture
// result against a cycle-free model of the meter kept in the bench.
// ----------------------------------------------------------------------------
module pwm_duty_frequency_meter_tb;
    import pwmm_pkg::*;

    localparam int CW = CNT_BITS_DEF;

    typedef struct packed {
        logic                  kind;
        logic [TICKS_BITS-1:0] high;
        logic [TICKS_BITS-1:0] low;
        logic [DUTY_BITS-1:0]  duty;
        logic [FREQ_BITS-1:0]  freq;
        logic                  pzero;
    } capture_t;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr        = REG_TPS_ADDR;
    logic [APB_DATA_BITS-1:0] pwdata       = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    logic                     signal_level = 1'b0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    logic                     edge_kind;
    logic [TICKS_BITS-1:0]    high_ticks;
    logic [TICKS_BITS-1:0]    low_ticks;
    logic [DUTY_BITS-1:0]     duty_percent;
    logic [FREQ_BITS-1:0]     frequency;
    logic                     period_zero;

    // meter state as the bench sees it
    logic [CW-1:0]       tick_cnt  = '0;
    logic                want_fall = 1'b0;
    logic                prev_lvl  = 1'b0;
    logic [CW-1:0]       hi_time   = '0;
    logic [CW-1:0]       lo_time   = '0;
    logic [TPS_BITS-1:0] tick_rate = TPS_RESET;

    logic     sample_q[$];
    capture_t capture_q[$];
    int       err_count = 0;
    bit       no_idle   = 1'b0;
    bit       in_acc    = 1'b0;
    int       in_gap    = 0;
    int       out_hold  = 0;

    pwm_duty_frequency_meter #(
        .COUNTER_BITS (CW),
        .QUEUE_DEPTH  (QUEUE_DEPTH_DEF)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .signal_level (signal_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .edge_kind    (edge_kind),
        .high_ticks   (high_ticks),
        .low_ticks    (low_ticks),
        .duty_percent (duty_percent),
        .frequency    (frequency),
        .period_zero  (period_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("pwm_duty_frequency_meter verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR @%0t %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Advance the meter by one sample; returns 1 when the sample captures.
    function automatic bit meter_predict(input logic lvl, output capture_t res);
        logic [CW-1:0]   cnt;
        logic            rising;
        logic            falling;
        longint unsigned hi;
        longint unsigned per;
        longint unsigned q;
        res     = '0;
        cnt     = tick_cnt + 1'b1;
        rising  = lvl && !prev_lvl;
        falling = !lvl && prev_lvl;
        prev_lvl = lvl;
        if (!want_fall && rising)
        begin
            lo_time   = cnt;
            res.kind  = EDGE_RISE;
            want_fall = 1'b1;
        end
        else if (want_fall && falling)
        begin
            hi_time   = cnt;
            res.kind  = EDGE_FALL;
            want_fall = 1'b0;
        end
        else
        begin
            tick_cnt = cnt;
            return 1'b0;
        end
        tick_cnt = '0;
        hi  = hi_time;
        per = hi;
        per += lo_time;
        res.high = hi_time[TICKS_BITS-1:0];
        res.low  = lo_time[TICKS_BITS-1:0];
        if (per == 0)
            res.pzero = 1'b1;
        else
        begin
            q        = (hi * DUTY_SCALE) / per;
            res.duty = q[DUTY_BITS-1:0];
            q        = tick_rate / per;
            res.freq = (q > 65535) ? 16'hFFFF : q[FREQ_BITS-1:0];
        end
        return 1'b1;
    endfunction

    function automatic int next_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sample driver
    always @(negedge clk)
    begin
        if (!in_valid || in_acc)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (sample_q.size() != 0)
            begin
                signal_level <= sample_q.pop_front();
                in_valid     <= 1'b1;
                in_gap = next_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0)
                out_hold = next_gap();
        end
    end

    always @(posedge clk)
    begin : monitor
        capture_t res;
        capture_t got;
        capture_t want;
        bit       hit;
        in_acc = rst_n && in_valid && in_ready;
        if (in_acc)
        begin
            hit = meter_predict(signal_level, res);
            if (hit)
                capture_q.push_back(res);
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = {edge_kind, high_ticks, low_ticks, duty_percent, frequency, period_zero};
            if (capture_q.size() == 0)
                report_mismatch("result with nothing pending, high_ticks", got.high, 0);
            else
            begin
                want = capture_q.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("edge_kind", got.kind, want.kind);
                if (got.high !== want.high)
                    report_mismatch("high_ticks", got.high, want.high);
                if (got.low !== want.low)
                    report_mismatch("low_ticks", got.low, want.low);
                if (got.duty !== want.duty)
                    report_mismatch("duty_percent", got.duty, want.duty);
                if (got.freq !== want.freq)
                    report_mismatch("frequency", got.freq, want.freq);
                if (got.pzero !== want.pzero)
                    report_mismatch("period_zero", got.pzero, want.pzero);
            end
        end
    end

    // Optional write of the tick rate, then a read back of it.
    task automatic tick_rate_rw(input bit do_write, input logic [APB_DATA_BITS-1:0] data);
        logic [APB_DATA_BITS-1:0] rd;
        if (do_write)
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= REG_TPS_ADDR;
            pwdata  <= data;
            @(negedge clk);
            penable <= 1'b1;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            tick_rate = data[TPS_BITS-1:0];
        end
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_TPS_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[TPS_BITS-1:0] !== tick_rate)
            report_mismatch("ticks_per_second read back", rd[TPS_BITS-1:0], tick_rate);
    endtask

    task automatic push_run(input logic lvl, input int n);
        repeat (n) sample_q.push_back(lvl);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 20);
        return $urandom_range(21, 100);
    endfunction

    // mostly clean PWM bursts, some random bit noise
    task automatic queue_random(input int n);
        int cnt;
        int hi_len;
        int lo_len;
        int k;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                hi_len = pick_len();
                lo_len = pick_len();
                push_run(1'b1, hi_len);
                push_run(1'b0, lo_len);
                cnt += hi_len + lo_len;
            end
            else
            begin
                k = $urandom_range(1, 8);
                repeat (k) sample_q.push_back(1'($urandom_range(0, 1)));
                cnt += k;
            end
        end
    endtask

    // Wait out all samples and results, then the pipeline latency.
    task automatic drain();
        int waited;
        while (sample_q.size() != 0 || in_valid)
            @(posedge clk);
        waited = 0;
        while (capture_q.size() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        while (capture_q.size() != 0)
        begin
            report_mismatch("result never arrived, high_ticks", 0, capture_q[0].high);
            void'(capture_q.pop_front());
        end
        repeat (64) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic                     directed[] = '{1, 0, 1, 0, 1, 1, 1, 0, 0, 0, 0,
                                                 1, 0, 0, 1, 1, 1, 1, 1, 0, 1};
        logic [APB_DATA_BITS-1:0] rate;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tick_rate_rw(1'b0, '0);
        // first sample high is a rising edge; 1-tick phases saturate frequency
        foreach (directed[i])
            sample_q.push_back(directed[i]);
        queue_random(120);
        drain();

        tick_rate_rw(1'b1, 32'h00FF_FFFF);
        queue_random(120);
        drain();

        tick_rate_rw(1'b1, 32'h0000_0001);
        queue_random(100);
        drain();

        // upper bits are dropped, leaving a zero tick rate
        tick_rate_rw(1'b1, 32'hFF00_0000);
        queue_random(60);
        drain();

        rate = $urandom;
        if (rate[TPS_BITS-1:0] == 0)
            rate[0] = 1'b1;
        no_idle = 1'b1;
        tick_rate_rw(1'b1, rate);
        queue_random(100);
        drain();

        // short phases back to back at the default rate
        tick_rate_rw(1'b1, 32'd1000000);
        push_run(1'b1, 1);
        push_run(1'b0, 3);
        push_run(1'b1, 2);
        push_run(1'b0, 1);
        drain();
        no_idle = 1'b0;

        queue_random(100);
        drain();

        if (err_count == 0)
            $display("pwm_duty_frequency_meter verification clean");
        else
            $display("pwm_duty_frequency_meter verification failed");
        $finish;
    end

endmodule
